[sv/svalloc_pkg.sv]
package svalloc_pkg;

    localparam int NUM_VOICES_DEF  = 16;
    localparam int STACK_DEPTH_DEF = 16;
    localparam int MAX_CMDS        = 32;
    localparam int CNT_W           = 7;
    localparam int OP_W            = 4;

    // input function codes
    localparam logic [2:0] FN_NOTE_ON  = 3'd0;
    localparam logic [2:0] FN_NOTE_OFF = 3'd1;
    localparam logic [2:0] FN_MPE_ON   = 3'd2;
    localparam logic [2:0] FN_MPE_OFF  = 3'd3;
    localparam logic [2:0] FN_FINISHED = 3'd4;
    localparam logic [2:0] FN_ALL_OFF  = 3'd5;

    // result actions
    localparam logic [1:0] ACTION_START   = 2'd0;
    localparam logic [1:0] ACTION_RETUNE  = 2'd1;
    localparam logic [1:0] ACTION_RELEASE = 2'd2;
    localparam logic [1:0] ACTION_FREE    = 2'd3;

    // register indexes
    localparam logic [1:0] REG_SYNTH_MODE   = 2'd0;
    localparam logic [1:0] REG_VOICE_MODE   = 2'd1;
    localparam logic [1:0] REG_UNISON_COUNT = 2'd2;

    localparam logic [1:0] VM_MONO   = 2'd1;
    localparam logic [1:0] VM_LEGATO = 2'd2;

    // datapath operations
    localparam logic [OP_W-1:0] OP_SCAN   = 4'd0;
    localparam logic [OP_W-1:0] OP_FIND   = 4'd1;
    localparam logic [OP_W-1:0] OP_STK_RM = 4'd2;
    localparam logic [OP_W-1:0] OP_PUSH   = 4'd3;
    localparam logic [OP_W-1:0] OP_TOP    = 4'd4;
    localparam logic [OP_W-1:0] OP_VOFF   = 4'd5;
    localparam logic [OP_W-1:0] OP_CLR    = 4'd6;
    localparam logic [OP_W-1:0] OP_FLUSH  = 4'd7;

    // what a scan does on a matching voice
    localparam logic [1:0] SA_NONE   = 2'd0;
    localparam logic [1:0] SA_FREE   = 2'd1;
    localparam logic [1:0] SA_REL    = 2'd2;
    localparam logic [1:0] SA_RETUNE = 2'd3;

    typedef struct packed {
        logic [2:0] func;
        logic [6:0] note_number;
        logic [6:0] note_velocity;
        logic [4:0] midi_channel;
        logic       finished_pool;
        logic [3:0] finished_voice;
    } in_item_t;

    typedef struct packed {
        logic [1:0] action;
        logic       pool_sel;
        logic [3:0] voice_slot;
        logic [6:0] out_note;
        logic [6:0] out_velocity;
        logic [3:0] unison_slot;
        logic [4:0] unison_size;
        logic       last_cmd;
    } out_item_t;

    typedef struct packed {
        logic             go;
        logic             load;
        logic [OP_W-1:0]  op;
        logic             pool;
        logic             c_use;
        logic             c_act;
        logic             c_note;
        logic             c_chan;
        logic             first;
        logic [1:0]       sact;
        logic [CNT_W-1:0] uslot;
        logic [CNT_W-1:0] usize;
        logic             set_chan;
    } dp_cmd_t;

    typedef struct packed {
        logic             done;
        logic             found;
        logic             stack_nonempty;
        logic [2:0]       func;
        logic             synth_mode;
        logic [1:0]       voice_mode;
        logic [CNT_W-1:0] uni_n;
        logic             chan_ok;
    } dp_stat_t;

endpackage

[sv/synth_voice_allocator_top.sv]
// polyphonic voice allocator: one note event in on start (taken while busy is low), a
// burst of voice commands out, each shown for a single cycle on result with
// result_strobe high. the receiver cannot stall, so every strobed command must be
// captured in that cycle; the final command of an event has last_cmd set, and
// events that cause nothing produce no strobe at all. an event takes a decode step
// plus one pass per voice scan: each scan or voice search walks the pool one voice
// a cycle, and the note stack search and shift walks one entry a cycle.
// configuration writes are only taken while busy is low
module synth_voice_allocator_top #(
    parameter int NUM_VOICES  = svalloc_pkg::NUM_VOICES_DEF,
    parameter int STACK_DEPTH = svalloc_pkg::STACK_DEPTH_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  svalloc_pkg::in_item_t  request,
    output svalloc_pkg::out_item_t result,
    output logic                   result_strobe,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [4:0]             cfg_data
);
    import svalloc_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // writes are held off while an event is in flight
    assign cfg_ready = !busy;

    // sequencer: walks the steps of each event kind
    svalloc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd),
        .stat  (stat)
    );

    // voice tables, note stack, registers and the command output stage
    svalloc_dp #(
        .NV (NUM_VOICES),
        .SD (STACK_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid & cfg_ready),
        .cfg_idx       (cfg_index),
        .cfg_data      (cfg_data),
        .request       (request),
        .result        (result),
        .result_strobe (result_strobe)
    );

endmodule

[sv/svalloc_dp.sv]
module svalloc_dp #(
    parameter int NV = 16,
    parameter int SD = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  svalloc_pkg::dp_cmd_t  cmd,
    output svalloc_pkg::dp_stat_t stat,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_idx,
    input  logic [4:0]            cfg_data,
    input  svalloc_pkg::in_item_t request,
    output svalloc_pkg::out_item_t result,
    output logic                  result_strobe
);
    import svalloc_pkg::*;

    localparam int IW   = (NV > 1) ? $clog2(NV) : 1;
    localparam int ALLV = 2 * NV;
    localparam int KW   = $clog2(ALLV);
    localparam int CW   = $clog2(NV + 1);
    localparam int SIW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int SCW  = $clog2(SD + 1);

    logic [ALLV-1:0] in_use_reg;
    logic [ALLV-1:0] active_reg;
    logic [6:0]      note_reg [ALLV];
    logic [31:0]     age_reg  [ALLV];
    logic [4:0]      chan_reg [NV];
    logic [31:0]     age_cnt_reg;
    logic [6:0]      held_mem [SD];
    logic [SCW-1:0]  held_cnt_reg;
    logic [6:0]      held_vel_reg;

    logic            synth_mode_reg;
    logic [1:0]      voice_mode_reg;
    logic [4:0]      unison_reg;

    in_item_t        req_reg;
    logic [6:0]      wnote_reg;
    logic [6:0]      wvel_reg;

    dp_cmd_t         scmd_reg;
    logic            run_reg;
    logic [CW-1:0]   cnt_reg;
    logic            phase_reg;
    logic            found_reg;
    logic            done_reg;
    logic [IW-1:0]   best_reg;
    logic [31:0]     best_age_reg;
    logic            have_reg;
    logic [SCW-1:0]  sj_reg;

    out_item_t       pend_reg;
    logic            pend_v_reg;
    out_item_t       res_reg;
    logic            strobe_reg;
    logic [5:0]      ecnt_reg;

    function automatic logic [KW-1:0] k_of(input logic pool, input logic [IW-1:0] idx);
        k_of = pool ? (KW'(NV) + KW'(idx)) : KW'(idx);
    endfunction

    logic [IW-1:0]   idx;
    logic [KW-1:0]   k;
    logic            scan_end;
    logic            match;
    logic            start_go;
    logic [IW-1:0]   sidx;
    logic [KW-1:0]   ks;
    logic            older;
    logic [SCW-1:0]  sj_inc;
    logic [SCW-1:0]  top_idx;
    logic            hw_en;
    logic [SIW-1:0]  hw_idx;
    logic [6:0]      hw_data;
    logic            gen;
    out_item_t       gen_item;
    logic            flush;
    logic [KW-1:0]   kf;
    logic [CNT_W-1:0] uni_n;

    always_comb
    begin
        idx      = cnt_reg[IW-1:0];
        k        = k_of(scmd_reg.pool, idx);
        scan_end = (cnt_reg == CW'(NV));
        match    = 1'b0;
        older    = 1'b0;
        start_go = 1'b0;
        sidx     = best_reg;
        if (!scan_end)
        begin
            match = (!scmd_reg.c_use  || in_use_reg[k])
                 && (!scmd_reg.c_act  || active_reg[k])
                 && (!scmd_reg.c_note || (note_reg[k] == wnote_reg))
                 && (!scmd_reg.c_chan || (chan_reg[idx] == req_reg.midi_channel));
            older = !have_reg || (age_reg[k] < best_age_reg);
            if (!in_use_reg[k])
            begin
                start_go = 1'b1;
                sidx     = idx;
            end
        end
        else
        begin
            start_go = 1'b1;
        end
        ks      = k_of(scmd_reg.pool, sidx);
        sj_inc  = sj_reg + 1'b1;
        top_idx = held_cnt_reg - 1'b1;
        kf      = k_of(req_reg.finished_pool, IW'(req_reg.finished_voice));

        if (unison_reg == 5'd0)
            uni_n = CNT_W'(1);
        else if (32'(unison_reg) > NV)
            uni_n = CNT_W'(NV);
        else
            uni_n = CNT_W'(unison_reg);

        // stack write port: shift down or push
        hw_en   = 1'b0;
        hw_idx  = sj_reg[SIW-1:0];
        hw_data = held_mem[sj_inc[SIW-1:0]];
        if (run_reg && (scmd_reg.op == OP_STK_RM) && phase_reg && (sj_inc < held_cnt_reg))
            hw_en = 1'b1;
        if (run_reg && (scmd_reg.op == OP_PUSH) && (held_cnt_reg < SCW'(SD)))
        begin
            hw_en   = 1'b1;
            hw_idx  = held_cnt_reg[SIW-1:0];
            hw_data = wnote_reg;
        end

        // command generation
        gen      = 1'b0;
        gen_item = '0;
        gen_item.unison_size = 5'd1;
        gen_item.pool_sel    = scmd_reg.pool;
        if (run_reg && (scmd_reg.op == OP_SCAN) && match && (scmd_reg.sact != SA_NONE))
        begin
            gen = 1'b1;
            gen_item.voice_slot = 4'(idx);
            gen_item.out_note   = note_reg[k];
            case (scmd_reg.sact)
                SA_FREE:   gen_item.action = ACTION_FREE;
                SA_REL:    gen_item.action = ACTION_RELEASE;
                SA_RETUNE:
                begin
                    gen_item.action   = ACTION_RETUNE;
                    gen_item.out_note = wnote_reg;
                end
                default:   gen_item.action = ACTION_RELEASE;
            endcase
        end
        if (run_reg && (scmd_reg.op == OP_FIND) && start_go)
        begin
            gen = 1'b1;
            gen_item.action       = ACTION_START;
            gen_item.voice_slot   = 4'(sidx);
            gen_item.out_note     = wnote_reg;
            gen_item.out_velocity = wvel_reg;
            gen_item.unison_slot  = 4'(scmd_reg.uslot);
            gen_item.unison_size  = 5'(scmd_reg.usize);
        end
        flush = run_reg && (scmd_reg.op == OP_FLUSH);
    end

    always_ff @(posedge clk)
    begin
        if (hw_en)
            held_mem[hw_idx] <= hw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_use_reg     <= '0;
            active_reg     <= '0;
            for (int i = 0; i < ALLV; i++)
            begin
                note_reg[i] <= '0;
                age_reg[i]  <= '0;
            end
            for (int i = 0; i < NV; i++)
                chan_reg[i] <= '0;
            age_cnt_reg    <= '0;
            held_cnt_reg   <= '0;
            held_vel_reg   <= '0;
            synth_mode_reg <= 1'b0;
            voice_mode_reg <= 2'd0;
            unison_reg     <= 5'd1;
            run_reg        <= 1'b0;
            done_reg       <= 1'b0;
            found_reg      <= 1'b0;
            cnt_reg        <= '0;
            phase_reg      <= 1'b0;
            have_reg       <= 1'b0;
            sj_reg         <= '0;
            scmd_reg       <= '0;
            req_reg        <= '0;
            wnote_reg      <= '0;
            wvel_reg       <= '0;
            best_reg       <= '0;
            best_age_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                case (cfg_idx)
                    REG_SYNTH_MODE:
                    begin
                        if (cfg_data[0] != synth_mode_reg)
                            held_cnt_reg <= '0;
                        synth_mode_reg <= cfg_data[0];
                    end
                    REG_VOICE_MODE:   voice_mode_reg <= cfg_data[1:0];
                    REG_UNISON_COUNT: unison_reg     <= cfg_data;
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                req_reg   <= request;
                wnote_reg <= request.note_number;
                wvel_reg  <= request.note_velocity;
            end
            if (cmd.go)
            begin
                scmd_reg  <= cmd;
                run_reg   <= 1'b1;
                cnt_reg   <= '0;
                phase_reg <= 1'b0;
                found_reg <= 1'b0;
                have_reg  <= 1'b0;
                sj_reg    <= '0;
            end
            else if (run_reg)
            begin
                case (scmd_reg.op)
                    OP_SCAN:
                    begin
                        if (scan_end)
                        begin
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            if (match)
                            begin
                                found_reg <= 1'b1;
                                if (scmd_reg.sact == SA_FREE)
                                    in_use_reg[k] <= 1'b0;
                                if (scmd_reg.sact == SA_RETUNE)
                                    note_reg[k] <= wnote_reg;
                            end
                            if (match && scmd_reg.first)
                            begin
                                run_reg  <= 1'b0;
                                done_reg <= 1'b1;
                            end
                            else
                                cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    OP_FIND:
                    begin
                        if (start_go)
                        begin
                            in_use_reg[ks] <= 1'b1;
                            active_reg[ks] <= 1'b1;
                            note_reg[ks]   <= wnote_reg;
                            age_reg[ks]    <= age_cnt_reg;
                            age_cnt_reg    <= age_cnt_reg + 1'b1;
                            if (scmd_reg.set_chan)
                                chan_reg[sidx] <= req_reg.midi_channel;
                            run_reg  <= 1'b0;
                            done_reg <= 1'b1;
                        end
                        else
                        begin
                            if (older)
                            begin
                                best_reg     <= idx;
                                best_age_reg <= age_reg[k];
                                have_reg     <= 1'b1;
                            end
                            cnt_reg <= cnt_reg + 1'b1;
                        end
                    end
                    OP_STK_RM:
                    begin
                        if (!phase_reg)
                        begin
                            if (sj_reg >= held_cnt_reg)
                            begin
                                run_reg  <= 1'b0;
                                done_reg <= 1'b1;
                            end
                            else if (held_mem[sj_reg[SIW-1:0]] == wnote_reg)
                                phase_reg <= 1'b1;
                            else
                                sj_reg <= sj_inc;
                        end
                        else if (sj_inc < held_cnt_reg)
                            sj_reg <= sj_inc;
                        else
                        begin
                            held_cnt_reg <= held_cnt_reg - 1'b1;
                            run_reg      <= 1'b0;
                            done_reg     <= 1'b1;
                        end
                    end
                    OP_PUSH:
                    begin
                        if (held_cnt_reg < SCW'(SD))
                            held_cnt_reg <= held_cnt_reg + 1'b1;
                        held_vel_reg <= wvel_reg;
                        run_reg      <= 1'b0;
                        done_reg     <= 1'b1;
                    end
                    OP_TOP:
                    begin
                        wnote_reg <= held_mem[top_idx[SIW-1:0]];
                        wvel_reg  <= held_vel_reg;
                        run_reg   <= 1'b0;
                        done_reg  <= 1'b1;
                    end
                    OP_VOFF:
                    begin
                        if (32'(req_reg.finished_voice) < NV)
                        begin
                            in_use_reg[kf] <= 1'b0;
                            active_reg[kf] <= 1'b0;
                        end
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                    OP_CLR:
                    begin
                        held_cnt_reg <= '0;
                        run_reg      <= 1'b0;
                        done_reg     <= 1'b1;
                    end
                    default:
                    begin
                        run_reg  <= 1'b0;
                        done_reg <= 1'b1;
                    end
                endcase
            end
        end
    end

    // one command held back so the final one of an item can be marked
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_v_reg <= 1'b0;
            strobe_reg <= 1'b0;
            ecnt_reg   <= '0;
        end
        else
        begin
            strobe_reg <= 1'b0;
            if (cmd.load)
                ecnt_reg <= '0;
            if (gen && (ecnt_reg < 6'(MAX_CMDS)))
            begin
                if (pend_v_reg)
                begin
                    res_reg    <= pend_reg;
                    strobe_reg <= 1'b1;
                end
                pend_reg   <= gen_item;
                pend_v_reg <= 1'b1;
                ecnt_reg   <= ecnt_reg + 1'b1;
            end
            else if (flush && pend_v_reg)
            begin
                res_reg          <= pend_reg;
                res_reg.last_cmd <= 1'b1;
                strobe_reg       <= 1'b1;
                pend_v_reg       <= 1'b0;
            end
        end
    end

    always_comb
    begin
        stat.done           = done_reg;
        stat.found          = found_reg;
        stat.stack_nonempty = (held_cnt_reg != '0);
        stat.func           = req_reg.func;
        stat.synth_mode     = synth_mode_reg;
        stat.voice_mode     = voice_mode_reg;
        stat.uni_n          = uni_n;
        stat.chan_ok        = (req_reg.midi_channel >= 5'd2) && (req_reg.midi_channel <= 5'd16);
    end

    assign result        = res_reg;
    assign result_strobe = strobe_reg;

endmodule

[sv/svalloc_ctrl.sv]
module svalloc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    output svalloc_pkg::dp_cmd_t  cmd,
    input  svalloc_pkg::dp_stat_t stat
);
    import svalloc_pkg::*;

    localparam logic [4:0] S_IDLE       = 5'd0;
    localparam logic [4:0] S_DECODE     = 5'd1;
    localparam logic [4:0] S_FM_SCAN    = 5'd2;
    localparam logic [4:0] S_FM_START   = 5'd3;
    localparam logic [4:0] S_STK_RM     = 5'd4;
    localparam logic [4:0] S_STK_PUSH   = 5'd5;
    localparam logic [4:0] S_GATE       = 5'd6;
    localparam logic [4:0] S_RETUNE     = 5'd7;
    localparam logic [4:0] S_FREE_ALL   = 5'd8;
    localparam logic [4:0] S_MONO_START = 5'd9;
    localparam logic [4:0] S_POLY_FREE  = 5'd10;
    localparam logic [4:0] S_POLY_START = 5'd11;
    localparam logic [4:0] S_OFF_RM     = 5'd12;
    localparam logic [4:0] S_OFF_TOP    = 5'd13;
    localparam logic [4:0] S_FM_REL     = 5'd14;
    localparam logic [4:0] S_MONO_REL   = 5'd15;
    localparam logic [4:0] S_POLY_REL   = 5'd16;
    localparam logic [4:0] S_MPE_FREE   = 5'd17;
    localparam logic [4:0] S_MPE_START  = 5'd18;
    localparam logic [4:0] S_MPE_REL    = 5'd19;
    localparam logic [4:0] S_VOFF       = 5'd20;
    localparam logic [4:0] S_CLR        = 5'd21;
    localparam logic [4:0] S_ALL0       = 5'd22;
    localparam logic [4:0] S_ALL1       = 5'd23;
    localparam logic [4:0] S_FLUSH      = 5'd24;

    logic [4:0]       state_reg;
    logic [4:0]       state_next;
    logic [4:0]       decode_next;
    logic             wait_reg;
    logic [CNT_W-1:0] uni_reg;
    logic             mono;
    logic             issue;

    assign mono  = (stat.voice_mode == VM_MONO) || (stat.voice_mode == VM_LEGATO);
    assign busy  = (state_reg != S_IDLE);
    assign issue = (state_reg != S_IDLE) && (state_reg != S_DECODE) && !wait_reg;

    always_comb
    begin
        case (stat.func)
            FN_NOTE_ON:  decode_next = stat.synth_mode ? S_FM_SCAN :
                                       (mono ? S_STK_RM : S_POLY_FREE);
            FN_NOTE_OFF: decode_next = stat.synth_mode ? S_FM_REL :
                                       (mono ? S_OFF_RM : S_POLY_REL);
            FN_MPE_ON:   decode_next = stat.chan_ok ? S_MPE_FREE : S_FLUSH;
            FN_MPE_OFF:  decode_next = stat.chan_ok ? S_MPE_REL : S_FLUSH;
            FN_FINISHED: decode_next = S_VOFF;
            FN_ALL_OFF:  decode_next = S_CLR;
            default:     decode_next = S_FLUSH;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.usize = CNT_W'(1);
        cmd.load  = start && (state_reg == S_IDLE);
        cmd.go    = issue;
        cmd.op    = OP_SCAN;
        state_next = S_FLUSH;
        case (state_reg)
            S_FM_SCAN:
            begin
                cmd.pool = 1'b1; cmd.c_use = 1'b1; cmd.c_act = 1'b1; cmd.c_note = 1'b1;
                cmd.first = 1'b1; cmd.sact = SA_FREE;
                state_next = S_FM_START;
            end
            S_FM_START:
            begin
                cmd.op = OP_FIND; cmd.pool = 1'b1;
            end
            S_STK_RM:
            begin
                cmd.op = OP_STK_RM;
                state_next = S_STK_PUSH;
            end
            S_STK_PUSH:
            begin
                cmd.op = OP_PUSH;
                state_next = S_GATE;
            end
            S_GATE:
            begin
                cmd.c_use = 1'b1; cmd.c_act = 1'b1; cmd.first = 1'b1; cmd.sact = SA_NONE;
                state_next = ((stat.voice_mode == VM_LEGATO) && stat.found) ?
                             S_RETUNE : S_FREE_ALL;
            end
            S_RETUNE:
            begin
                cmd.c_use = 1'b1; cmd.first = 1'b1; cmd.sact = SA_RETUNE;
            end
            S_FREE_ALL:
            begin
                cmd.c_use = 1'b1; cmd.sact = SA_FREE;
                state_next = S_MONO_START;
            end
            S_MONO_START, S_MPE_START:
            begin
                cmd.op = OP_FIND;
                cmd.set_chan = (state_reg == S_MPE_START);
            end
            S_POLY_FREE:
            begin
                cmd.c_use = 1'b1; cmd.c_note = 1'b1; cmd.sact = SA_FREE;
                state_next = S_POLY_START;
            end
            S_POLY_START:
            begin
                cmd.op = OP_FIND; cmd.uslot = uni_reg; cmd.usize = stat.uni_n;
                state_next = ((uni_reg + 1'b1) < stat.uni_n) ? S_POLY_START : S_FLUSH;
            end
            S_OFF_RM:
            begin
                cmd.op = OP_STK_RM;
                state_next = stat.stack_nonempty ? S_OFF_TOP : S_MONO_REL;
            end
            S_OFF_TOP:
            begin
                cmd.op = OP_TOP;
                state_next = (stat.voice_mode == VM_LEGATO) ? S_RETUNE : S_FREE_ALL;
            end
            S_FM_REL:
            begin
                cmd.pool = 1'b1; cmd.c_use = 1'b1; cmd.c_act = 1'b1; cmd.c_note = 1'b1;
                cmd.first = 1'b1; cmd.sact = SA_REL;
            end
            S_MONO_REL:
            begin
                cmd.c_use = 1'b1; cmd.first = 1'b1; cmd.sact = SA_REL;
            end
            S_POLY_REL:
            begin
                cmd.c_use = 1'b1; cmd.c_note = 1'b1; cmd.sact = SA_REL;
            end
            S_MPE_FREE:
            begin
                cmd.c_use = 1'b1; cmd.c_chan = 1'b1; cmd.first = 1'b1; cmd.sact = SA_FREE;
                state_next = S_MPE_START;
            end
            S_MPE_REL:
            begin
                cmd.c_use = 1'b1; cmd.c_chan = 1'b1; cmd.c_note = 1'b1;
                cmd.first = 1'b1; cmd.sact = SA_REL;
            end
            S_VOFF:
            begin
                cmd.op = OP_VOFF;
            end
            S_CLR:
            begin
                cmd.op = OP_CLR;
                state_next = S_ALL0;
            end
            S_ALL0, S_ALL1:
            begin
                cmd.pool = (state_reg == S_ALL1); cmd.c_use = 1'b1; cmd.c_act = 1'b1;
                cmd.sact = SA_REL;
                state_next = (state_reg == S_ALL0) ? S_ALL1 : S_FLUSH;
            end
            S_FLUSH:
            begin
                cmd.op = OP_FLUSH;
                state_next = S_IDLE;
            end
            default:
            begin
                cmd.go = 1'b0;
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wait_reg  <= 1'b0;
            uni_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                        state_reg <= S_DECODE;
                end
                S_DECODE:
                begin
                    uni_reg   <= '0;
                    state_reg <= decode_next;
                end
                default:
                begin
                    if (issue)
                        wait_reg <= 1'b1;
                    if (stat.done)
                    begin
                        wait_reg  <= 1'b0;
                        state_reg <= state_next;
                        if (state_reg == S_POLY_START)
                            uni_reg <= uni_reg + 1'b1;
                    end
                end
            endcase
        end
    end

endmodule

[tb/testbench.sv]
module testbench;
    import svalloc_pkg::*;

    // voice modes and pools as the allocator sees them
    localparam logic [1:0] VM_POLY  = 2'd0;
    localparam logic [1:0] VM_SPARE = 2'd3;
    localparam logic       POOL_MAIN = 1'b0;
    localparam logic       POOL_FM   = 1'b1;
    localparam int NV = 16;
    localparam int SD = 16;
    // quiet time before a register write or the end, covers the slowest silent event
    localparam int SETTLE_CYCLES = 300;
    localparam int ITEMS_PER_PHASE = 37;
    localparam int NO_IDLE_FROM = 290;

    // row kinds of the directed table
    localparam int ROW_PREDICT  = 0;
    localparam int ROW_ONE_CMD  = 1;
    localparam int ROW_SILENT   = 2;

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  request;
    out_item_t result;
    logic      result_strobe;
    logic      cfg_valid;
    logic      cfg_ready;
    logic [1:0] cfg_index;
    logic [4:0] cfg_data;

    synth_voice_allocator_top u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .result(result), .result_strobe(result_strobe), .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------------
    // allocator state as predicted: main pool in 0..15, fm pool in 16..31
    // ---------------------------------------------------------------------
    bit          v_in_use [2*NV];
    bit          v_active [2*NV];
    logic [6:0]  v_note   [2*NV];
    logic [31:0] v_age    [2*NV];
    logic [4:0]  v_chan   [NV];
    logic [31:0] age_ctr;
    logic [6:0]  held     [SD];
    int          held_n;
    logic [6:0]  held_vel;
    logic        synth_reg;
    logic [1:0]  vmode_reg;
    logic [4:0]  unison_reg;

    out_item_t expected_cmds [$];   // voice commands still to come from the block
    out_item_t event_cmds [$];      // commands of the event being predicted
    bit        mismatch_seen;
    int        items_sent;
    logic [6:0] recent_notes [8];   // notes recently struck, for well-formed note offs

    task automatic queue_cmd(logic [1:0] act, logic pool, int slot, logic [6:0] note,
                             logic [6:0] vel, int uslot, int usize);
        out_item_t c;
        c.action       = act;
        c.pool_sel     = pool;
        c.voice_slot   = slot[3:0];
        c.out_note     = note;
        c.out_velocity = vel;
        c.unison_slot  = uslot[3:0];
        c.unison_size  = usize[4:0];
        c.last_cmd     = 1'b0;
        // anything past the command limit is lost, state still moves on
        if (event_cmds.size() < MAX_CMDS)
            event_cmds.push_back(c);
    endtask

    // first free voice, else the oldest one (lowest index on a tie)
    function automatic int pick_voice(logic pool);
        int base;
        int best;
        bit have;
        base = pool * NV;
        best = 0;
        have = 0;
        for (int i = 0; i < NV; i++)
        begin
            if (!v_in_use[base+i])
                return i;
            if (!have || v_age[base+i] < v_age[base+best])
            begin
                best = i;
                have = 1;
            end
        end
        return best;
    endfunction

    task automatic voice_on(logic pool, int i, logic [6:0] note, logic [6:0] vel,
                            int uslot, int usize);
        int k;
        k = pool * NV + i;
        v_in_use[k] = 1;
        v_active[k] = 1;
        v_note[k]   = note;
        v_age[k]    = age_ctr;
        age_ctr     = age_ctr + 1;
        queue_cmd(ACTION_START, pool, i, note, vel, uslot, usize);
    endtask

    task automatic voice_free(logic pool, int i);
        int k;
        k = pool * NV + i;
        queue_cmd(ACTION_FREE, pool, i, v_note[k], 7'd0, 0, 1);
        v_in_use[k] = 0;
    endtask

    function automatic bit main_gate_open();
        for (int i = 0; i < NV; i++)
            if (v_in_use[i] && v_active[i])
                return 1;
        return 0;
    endfunction

    task automatic held_drop(logic [6:0] note);
        for (int i = 0; i < held_n; i++)
        begin
            if (held[i] == note)
            begin
                for (int j = i; j + 1 < held_n; j++)
                    held[j] = held[j+1];
                held_n--;
                return;
            end
        end
    endtask

    task automatic legato_retune(logic [6:0] note);
        for (int i = 0; i < NV; i++)
        begin
            if (v_in_use[i])
            begin
                v_note[i] = note;
                queue_cmd(ACTION_RETUNE, POOL_MAIN, i, note, 7'd0, 0, 1);
                return;
            end
        end
    endtask

    task automatic mono_restart(logic [6:0] note, logic [6:0] vel);
        for (int i = 0; i < NV; i++)
            if (v_in_use[i])
                voice_free(POOL_MAIN, i);
        voice_on(POOL_MAIN, pick_voice(POOL_MAIN), note, vel, 0, 1);
    endtask

    task automatic strike_note(logic [6:0] note, logic [6:0] vel);
        int n;
        bit open;
        if (synth_reg == POOL_FM)
        begin
            for (int i = 0; i < NV; i++)
            begin
                if (v_in_use[NV+i] && v_active[NV+i] && v_note[NV+i] == note)
                begin
                    voice_free(POOL_FM, i);
                    break;
                end
            end
            voice_on(POOL_FM, pick_voice(POOL_FM), note, vel, 0, 1);
            return;
        end
        if (vmode_reg == VM_MONO || vmode_reg == VM_LEGATO)
        begin
            held_drop(note);
            // a full stack keeps its notes and ignores the new one
            if (held_n < SD)
            begin
                held[held_n] = note;
                held_n++;
            end
            held_vel = vel;
            open = main_gate_open();
            if (vmode_reg == VM_LEGATO && open)
                legato_retune(note);
            else
                mono_restart(note, vel);
            return;
        end
        for (int i = 0; i < NV; i++)
            if (v_in_use[i] && v_note[i] == note)
                voice_free(POOL_MAIN, i);
        n = unison_reg;
        if (n < 1)
            n = 1;
        if (n > NV)
            n = NV;
        for (int u = 0; u < n; u++)
            voice_on(POOL_MAIN, pick_voice(POOL_MAIN), note, vel, u, n);
    endtask

    task automatic lift_note(logic [6:0] note);
        if (synth_reg == POOL_FM)
        begin
            for (int i = 0; i < NV; i++)
            begin
                if (v_in_use[NV+i] && v_active[NV+i] && v_note[NV+i] == note)
                begin
                    queue_cmd(ACTION_RELEASE, POOL_FM, i, note, 7'd0, 0, 1);
                    break;
                end
            end
            return;
        end
        if (vmode_reg == VM_MONO || vmode_reg == VM_LEGATO)
        begin
            held_drop(note);
            if (held_n > 0)
            begin
                if (vmode_reg == VM_LEGATO)
                    legato_retune(held[held_n-1]);
                else
                    mono_restart(held[held_n-1], held_vel);
            end
            else
            begin
                for (int i = 0; i < NV; i++)
                begin
                    if (v_in_use[i])
                    begin
                        queue_cmd(ACTION_RELEASE, POOL_MAIN, i, v_note[i], 7'd0, 0, 1);
                        break;
                    end
                end
            end
            return;
        end
        for (int i = 0; i < NV; i++)
            if (v_in_use[i] && v_note[i] == note)
                queue_cmd(ACTION_RELEASE, POOL_MAIN, i, note, 7'd0, 0, 1);
    endtask

    // works out the voice commands of one accepted event and queues them
    task automatic allocate_event(in_item_t ev);
        int i;
        event_cmds.delete();
        case (ev.func)
            FN_NOTE_ON:  strike_note(ev.note_number, ev.note_velocity);
            FN_NOTE_OFF: lift_note(ev.note_number);
            FN_MPE_ON:
            begin
                if (ev.midi_channel >= 2 && ev.midi_channel <= 16)
                begin
                    for (i = 0; i < NV; i++)
                    begin
                        if (v_in_use[i] && v_chan[i] == ev.midi_channel)
                        begin
                            voice_free(POOL_MAIN, i);
                            break;
                        end
                    end
                    i = pick_voice(POOL_MAIN);
                    v_chan[i] = ev.midi_channel;
                    voice_on(POOL_MAIN, i, ev.note_number, ev.note_velocity, 0, 1);
                end
            end
            FN_MPE_OFF:
            begin
                if (ev.midi_channel >= 2 && ev.midi_channel <= 16)
                begin
                    for (i = 0; i < NV; i++)
                    begin
                        if (v_in_use[i] && v_chan[i] == ev.midi_channel &&
                            v_note[i] == ev.note_number)
                        begin
                            queue_cmd(ACTION_RELEASE, POOL_MAIN, i, ev.note_number,
                                      7'd0, 0, 1);
                            break;
                        end
                    end
                end
            end
            FN_FINISHED:
            begin
                v_active[ev.finished_pool*NV + ev.finished_voice] = 0;
                v_in_use[ev.finished_pool*NV + ev.finished_voice] = 0;
            end
            FN_ALL_OFF:
            begin
                held_n = 0;
                for (int k = 0; k < 2*NV; k++)
                    if (v_in_use[k] && v_active[k])
                        queue_cmd(ACTION_RELEASE, k / NV, k % NV, v_note[k], 7'd0, 0, 1);
            end
            default: ;  // spare function codes do nothing
        endcase
        if (event_cmds.size() > 0)
            event_cmds[event_cmds.size()-1].last_cmd = 1'b1;
        foreach (event_cmds[j])
            expected_cmds.push_back(event_cmds[j]);
    endtask

    // ---------------------------------------------------------------------
    // result side: the block cannot be stalled, every strobe is one command
    // ---------------------------------------------------------------------
    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_seen = 1;
        end
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && result_strobe)
        begin
            if (expected_cmds.size() == 0)
            begin
                $error("voice command with none expected: action %0d slot %0d",
                       result.action, result.voice_slot);
                mismatch_seen = 1;
            end
            else
            begin
                want = expected_cmds.pop_front();
                check_field("action", want.action, result.action);
                check_field("pool_sel", want.pool_sel, result.pool_sel);
                check_field("voice_slot", want.voice_slot, result.voice_slot);
                check_field("out_note", want.out_note, result.out_note);
                check_field("out_velocity", want.out_velocity, result.out_velocity);
                check_field("unison_slot", want.unison_slot, result.unison_slot);
                check_field("unison_size", want.unison_size, result.unison_size);
                check_field("last_cmd", want.last_cmd, result.last_cmd);
            end
        end
    end

    // ---------------------------------------------------------------------
    // request side
    // ---------------------------------------------------------------------
    // hands one event over and predicts it at the accepting edge
    task automatic send_event(in_item_t ev, bit idle_ok);
        int gap;
        if (idle_ok && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        request <= ev;
        do
            @(posedge clk);
        while (busy);
        allocate_event(ev);
        items_sent++;
    endtask

    // waits for the last command, then lets any silent scan run out
    task automatic drain();
        start <= 1'b0;
        while (expected_cmds.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [4:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_SYNTH_MODE:
            begin
                // switching pools empties the note stack
                if (value[0] != synth_reg)
                    held_n = 0;
                synth_reg = value[0];
            end
            REG_VOICE_MODE:   vmode_reg = value[1:0];
            REG_UNISON_COUNT: unison_reg = value;
            default: ;
        endcase
    endtask

    function automatic in_item_t make_event(logic [2:0] func, logic [6:0] note,
                                            logic [6:0] vel, logic [4:0] chan,
                                            logic pool, logic [3:0] voice);
        in_item_t ev;
        ev.func           = func;
        ev.note_number    = note;
        ev.note_velocity  = vel;
        ev.midi_channel   = chan;
        ev.finished_pool  = pool;
        ev.finished_voice = voice;
        return ev;
    endfunction

    function automatic out_item_t make_cmd(logic [1:0] act, int slot, logic [6:0] note,
                                           logic [6:0] vel);
        out_item_t c;
        c.action       = act;
        c.pool_sel     = POOL_MAIN;
        c.voice_slot   = slot[3:0];
        c.out_note     = note;
        c.out_velocity = vel;
        c.unison_slot  = 4'd0;
        c.unison_size  = 5'd1;
        c.last_cmd     = 1'b1;
        return c;
    endfunction

    // random event, the same for every mode: mostly note on / note off pairs
    function automatic in_item_t random_event();
        in_item_t ev;
        int roll;
        int slot;
        ev = make_event($urandom_range(0, 7), $urandom_range(0, 127), $urandom_range(0, 127),
                        $urandom_range(0, 31), $urandom_range(0, 1), $urandom_range(0, 15));
        roll = $urandom_range(0, 99);
        slot = $urandom_range(0, 7);
        if (roll < 45)
        begin
            ev.func = FN_NOTE_ON;
            // a narrow band makes repeated notes and retriggers common
            if ($urandom_range(0, 1) == 0)
                ev.note_number = $urandom_range(48, 63);
        end
        else if (roll < 72)
        begin
            ev.func = FN_NOTE_OFF;
            if ($urandom_range(0, 4) != 0)
                ev.note_number = recent_notes[slot];
        end
        else if (roll < 80)
        begin
            ev.func = FN_MPE_ON;
            if ($urandom_range(0, 5) != 0)
                ev.midi_channel = $urandom_range(2, 16);
        end
        else if (roll < 86)
        begin
            ev.func = FN_MPE_OFF;
            if ($urandom_range(0, 5) != 0)
            begin
                ev.midi_channel = $urandom_range(2, 16);
                ev.note_number  = recent_notes[slot];
            end
        end
        else if (roll < 94)
            ev.func = FN_FINISHED;
        else if (roll < 97)
            ev.func = FN_ALL_OFF;
        // else keep the random code, spare codes included
        return ev;
    endfunction

    typedef struct {
        in_item_t  ev;
        int        kind;
        out_item_t cmd;
    } directed_row_t;

    directed_row_t directed [19];

    // settings walked through after the directed part, extremes among them
    logic [4:0] phase_cfg [9][3] = '{
        '{5'd0, 5'(VM_POLY),   5'd1},
        '{5'd0, 5'(VM_POLY),   5'd16},
        '{5'd0, 5'(VM_MONO),   5'd0},
        '{5'd0, 5'(VM_LEGATO), 5'd31},
        '{5'd1, 5'(VM_POLY),   5'd3},
        '{5'd0, 5'(VM_SPARE),  5'd2},
        '{5'd1, 5'(VM_LEGATO), 5'd5},
        '{5'd0, 5'(VM_LEGATO), 5'd1},
        '{5'd0, 5'(VM_POLY),   5'd4}
    };

    initial
    begin
        bit idle_ok;
        in_item_t ev;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_SYNTH_MODE;
        cfg_data = '0;
        mismatch_seen = 0;
        items_sent = 0;
        foreach (v_in_use[k])
        begin
            v_in_use[k] = 0;
            v_active[k] = 0;
            v_note[k]   = '0;
            v_age[k]    = '0;
        end
        foreach (v_chan[k])
            v_chan[k] = '0;
        foreach (recent_notes[k])
            recent_notes[k] = 7'd60;
        age_ctr = '0;
        held_n = 0;
        held_vel = '0;
        synth_reg = POOL_MAIN;
        vmode_reg = VM_POLY;
        unison_reg = 5'd1;

        // directed events at reset settings: poly, main pool, no unison
        directed = '{
            '{make_event(FN_NOTE_ON, 60, 100, 0, 0, 0), ROW_ONE_CMD,
              make_cmd(ACTION_START, 0, 60, 100)},
            '{make_event(FN_NOTE_OFF, 60, 0, 0, 0, 0), ROW_ONE_CMD,
              make_cmd(ACTION_RELEASE, 0, 60, 0)},
            '{make_event(FN_FINISHED, 0, 0, 0, 0, 0), ROW_SILENT, '0},
            '{make_event(FN_NOTE_ON, 127, 127, 0, 0, 0), ROW_ONE_CMD,
              make_cmd(ACTION_START, 0, 127, 127)},
            '{make_event(FN_NOTE_ON, 0, 0, 0, 0, 0), ROW_ONE_CMD,
              make_cmd(ACTION_START, 1, 0, 0)},
            // same note again: old voice freed before the new start
            '{make_event(FN_NOTE_ON, 127, 1, 0, 0, 0), ROW_PREDICT, '0},
            '{make_event(FN_MPE_ON, 64, 90, 2, 0, 0), ROW_PREDICT, '0},
            '{make_event(FN_MPE_ON, 65, 80, 16, 0, 0), ROW_PREDICT, '0},
            '{make_event(FN_MPE_ON, 66, 70, 2, 0, 0), ROW_PREDICT, '0},
            '{make_event(FN_MPE_OFF, 66, 0, 2, 0, 0), ROW_PREDICT, '0},
            // channels outside the mpe zone are dropped
            '{make_event(FN_MPE_ON, 10, 10, 0, 0, 0), ROW_SILENT, '0},
            '{make_event(FN_MPE_ON, 10, 10, 1, 0, 0), ROW_SILENT, '0},
            '{make_event(FN_MPE_ON, 10, 10, 17, 0, 0), ROW_SILENT, '0},
            '{make_event(FN_MPE_OFF, 127, 127, 31, 1, 15), ROW_SILENT, '0},
            '{make_event(3'd6, 5, 5, 5, 0, 5), ROW_SILENT, '0},
            '{make_event(3'd7, 127, 127, 31, 1, 15), ROW_SILENT, '0},
            '{make_event(FN_FINISHED, 0, 0, 0, 1, 15), ROW_SILENT, '0},
            '{make_event(FN_ALL_OFF, 0, 0, 0, 0, 0), ROW_PREDICT, '0},
            '{make_event(FN_NOTE_OFF, 5, 0, 0, 0, 0), ROW_SILENT, '0}
        };

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[r])
        begin
            send_event(directed[r].ev, 1);
            // typed rows replace what was predicted with the value read off by hand
            if (directed[r].kind != ROW_PREDICT)
            begin
                repeat (event_cmds.size())
                    void'(expected_cmds.pop_back());
                if (directed[r].kind == ROW_ONE_CMD)
                    expected_cmds.push_back(directed[r].cmd);
            end
        end

        // random phases, one setting each, all registers rewritten while idle
        foreach (phase_cfg[p])
        begin
            drain();
            write_reg(REG_SYNTH_MODE, phase_cfg[p][0]);
            write_reg(REG_VOICE_MODE, phase_cfg[p][1]);
            write_reg(REG_UNISON_COUNT, phase_cfg[p][2]);
            @(posedge clk);
            // some phases run back to back with no idling at all
            idle_ok = ($urandom_range(0, 2) != 0);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                ev = random_event();
                if (ev.func == FN_NOTE_ON || ev.func == FN_MPE_ON)
                    recent_notes[$urandom_range(0, 7)] = ev.note_number;
                send_event(ev, idle_ok && items_sent < NO_IDLE_FROM);
            end
        end

        drain();
        if (!mismatch_seen && expected_cmds.size() == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    // leftover expectations are caught by the final check; this catches a hang
    initial
    begin
        #20000000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
